// ===== hw/rtl/srt_pkg.sv =====
package srt_pkg;

	localparam int SRT_MAX_SEGMENTS = 16;

	localparam logic OP_OPEN = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam logic [2:0] STAT_STORED  = 3'd0;
	localparam logic [2:0] STAT_COVERED = 3'd1;
	localparam logic [2:0] STAT_DONE    = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_BAD     = 3'd4;
	localparam logic [2:0] STAT_OPENED  = 3'd5;

	typedef struct packed {
		logic        op;
		logic [31:0] seg_start;
		logic [31:0] seg_end;
		logic [31:0] message_length;
	} seg_item_t;

	typedef struct packed {
		logic        complete;
		logic [2:0]  status;
		logic [31:0] bytes_remaining;
	} res_item_t;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
	} ent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DECIDE,
		ST_MOVE,
		ST_INSERT,
		ST_FINISH
	} srt_state_t;

endpackage

// ===== hw/rtl/segment_reassembly_tracker_top.sv =====
// Channel   Valid      Stall      Payload
// seg       seg_valid  seg_stall  seg (op, seg_start, seg_end, message_length)
// res       res_valid  res_stall  res (complete, status, bytes_remaining)
//
// An open, a bad segment or a segment after completion goes straight to the finish state.
// For a stored segment the table memory is walked once from the top entry down
// (one read a cycle), then the entries above the insertion point are moved
// through the same memory before the new interval is written.
// Reset is asynchronous and leaves an empty table with zero bytes remaining.
// seg_stall is high while an item is in work; res_stall holds a finished item
// in the output register and the next item may be taken meanwhile.
module segment_reassembly_tracker_top #(
	parameter int MAX_SEGMENTS = srt_pkg::SRT_MAX_SEGMENTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seg_valid,
	output logic              seg_stall,
	input  srt_pkg::seg_item_t seg,
	output logic              res_valid,
	input  logic              res_stall,
	output srt_pkg::res_item_t res
);
	import srt_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	srt_state_t state_q, state_d;

	ent_t mem_q [MAX_SEGMENTS];
	ent_t rd_q;
	logic rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	ent_t wr_data;

	logic [31:0] s_q, e_q, total_q, rem_q, add_q, sclip_q, rem_new_q;
	logic [CW-1:0] count_q, ins_q, r_q, newcnt_q, left_q;
	logic [IW-1:0] k_q, trim_idx_q, mv_q, pidx_s1;
	logic trim_q, pend_s1;
	logic [2:0] st_pend_q;
	logic cmp_pend_q;
	logic res_valid_q;
	res_item_t res_q;

	logic accept, res_free;
	logic acc_open, acc_done, acc_bad, acc_imm;
	logic gt, lt, sge, sgt, place, remove, drop, trim;
	logic [CW-1:0] cnt_m1, ins_plus_r;
	logic [CW:0] n_new_w, wa_w;
	logic full;

	assign accept   = seg_valid && (state_q == ST_IDLE);
	assign seg_stall = (state_q != ST_IDLE);
	assign res_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res      = res_q;

	assign acc_open = (seg.op == OP_OPEN);
	assign acc_done = (rem_q == 32'd0);
	assign acc_bad  = (seg.seg_end <= seg.seg_start) || (seg.seg_end > total_q);
	assign acc_imm  = acc_open || acc_done || acc_bad;

	// Compare the segment against the stored entry that was read last cycle.
	assign gt     = e_q > rd_q.hi;
	assign lt     = e_q < rd_q.hi;
	assign sgt    = s_q > rd_q.lo;
	assign sge    = s_q >= rd_q.lo;
	assign place  = gt && sgt;
	assign remove = (gt && !sgt) || (!gt && !lt && !sge);
	assign drop   = !gt && sge;
	assign trim   = lt && !sge && (e_q >= rd_q.lo);

	assign cnt_m1     = count_q - CW'(1);
	assign ins_plus_r = ins_q + r_q;
	assign n_new_w    = (CW+1)'(count_q) - (CW+1)'(r_q) + (CW+1)'(1);
	assign full       = n_new_w > (CW+1)'(MAX_SEGMENTS);
	assign wa_w       = (CW+1)'(pidx_s1) + (CW+1)'(1) - (CW+1)'(r_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (acc_imm)
						state_d = ST_FINISH;
					else if (count_q == '0)
						state_d = ST_DECIDE;
					else
						state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (drop)
					state_d = ST_FINISH;
				else if (place || (k_q == '0))
					state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = full ? ST_FINISH : ST_MOVE;
			ST_MOVE: begin
				if ((left_q == '0) && !pend_s1)
					state_d = ST_INSERT;
			end
			ST_INSERT: state_d = ST_FINISH;
			ST_FINISH: begin
				if (res_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			ST_IDLE: begin
				rd_en   = accept && (count_q != '0);
				rd_addr = cnt_m1[IW-1:0];
			end
			ST_WALK: begin
				rd_en   = (k_q != '0);
				rd_addr = k_q - IW'(1);
			end
			ST_MOVE: begin
				rd_en   = (left_q != '0);
				rd_addr = mv_q;
				wr_en   = pend_s1;
				wr_addr = wa_w[IW-1:0];
				wr_data.lo = (trim_q && (pidx_s1 == trim_idx_q)) ? e_q : rd_q.lo;
				wr_data.hi = rd_q.hi;
			end
			ST_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = ins_q[IW-1:0];
				wr_data.lo = sclip_q;
				wr_data.hi = e_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			total_q     <= '0;
			left_q      <= '0;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_FINISH) && res_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && acc_open) begin
						total_q <= seg.message_length;
						rem_q   <= seg.message_length;
						count_q <= '0;
					end
				end
				ST_DECIDE: begin
					left_q  <= count_q - ins_q - r_q;
					pend_s1 <= 1'b0;
				end
				ST_MOVE: begin
					pend_s1 <= (left_q != '0);
					if (left_q != '0)
						left_q <= left_q - CW'(1);
				end
				ST_INSERT: begin
					count_q <= newcnt_q;
					rem_q   <= rem_new_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					s_q        <= seg.seg_start;
					e_q        <= seg.seg_end;
					sclip_q    <= seg.seg_start;
					k_q        <= cnt_m1[IW-1:0];
					r_q        <= '0;
					add_q      <= '0;
					ins_q      <= '0;
					trim_q     <= 1'b0;
					cmp_pend_q <= 1'b0;
					if (acc_open)
						st_pend_q <= STAT_OPENED;
					else if (acc_done)
						st_pend_q <= STAT_DONE;
					else
						st_pend_q <= STAT_BAD;
				end
			end
			ST_WALK: begin
				k_q <= k_q - IW'(1);
				if (remove) begin
					r_q   <= r_q + CW'(1);
					add_q <= add_q + (rd_q.hi - rd_q.lo);
				end
				if (trim) begin
					add_q      <= add_q + (e_q - rd_q.lo);
					trim_q     <= 1'b1;
					trim_idx_q <= k_q;
				end
				if (place) begin
					ins_q   <= CW'(k_q) + CW'(1);
					sclip_q <= (s_q < rd_q.hi) ? rd_q.hi : s_q;
				end
				if (drop)
					st_pend_q <= STAT_COVERED;
			end
			ST_DECIDE: begin
				newcnt_q  <= n_new_w[CW-1:0];
				rem_new_q <= rem_q + add_q - (e_q - sclip_q);
				// With nothing removed the upper entries move up, so go from the top.
				mv_q      <= (r_q == '0) ? cnt_m1[IW-1:0] : ins_plus_r[IW-1:0];
				if (full)
					st_pend_q <= STAT_FULL;
			end
			ST_MOVE: begin
				if (left_q != '0) begin
					pidx_s1 <= mv_q;
					mv_q    <= (r_q == '0) ? (mv_q - IW'(1)) : (mv_q + IW'(1));
				end
			end
			ST_INSERT: begin
				st_pend_q  <= STAT_STORED;
				cmp_pend_q <= (rem_new_q == 32'd0);
			end
			ST_FINISH: begin
				if (res_free) begin
					res_q.complete        <= cmp_pend_q;
					res_q.status          <= st_pend_q;
					res_q.bytes_remaining <= rem_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SEGMENTS))
		else $error("interval count exceeds table depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("table read and write hit the same entry");

	a_insert_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |=> (state_q == ST_FINISH))
		else $error("insert not followed by result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !$past(res_valid)) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside finish state");

endmodule

// ===== test/tb_segment_reassembly_tracker_top.sv =====
module tb_segment_reassembly_tracker_top;
	timeunit 1ns;
	timeprecision 1ps;
	import srt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int NUM_RANDOM = 700;

	logic clk;
	logic arst_n;
	logic seg_valid;
	logic seg_stall;
	seg_item_t seg;
	logic res_valid;
	logic res_stall;
	res_item_t res;

	segment_reassembly_tracker_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg(seg),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow of the interval table, kept in ascending order.
	logic [31:0] shadow_lo [SRT_MAX_SEGMENTS];
	logic [31:0] shadow_hi [SRT_MAX_SEGMENTS];
	int unsigned shadow_count;
	logic [31:0] shadow_remaining;
	logic [31:0] shadow_total;

	seg_item_t pending_segs[$];
	res_item_t expected_results[$];
	int error_count;
	int results_seen;
	int completions_seen;
	int full_rejects;
	int covered_drops;
	bit quiet_phase;
	bit drain_hold;
	bit run_done;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what,
			got, want);
		error_count++;
	endtask

	function automatic res_item_t merge_segment(input seg_item_t item);
		res_item_t r;
		logic [31:0] ws [SRT_MAX_SEGMENTS + 1];
		logic [31:0] we [SRT_MAX_SEGMENTS + 1];
		logic [31:0] s, e, rem;
		int n, k, i, j;
		bit placed, dropped;
		r = '0;
		s = item.seg_start;
		e = item.seg_end;
		if (item.op == OP_OPEN) begin
			shadow_total = item.message_length;
			shadow_remaining = item.message_length;
			shadow_count = 0;
			r.status = STAT_OPENED;
		end else if (shadow_remaining == 0) begin
			r.status = STAT_DONE;
		end else if (e <= s || e > shadow_total) begin
			r.status = STAT_BAD;
		end else begin
			n = shadow_count;
			for (i = 0; i < n; i++) begin
				ws[i] = shadow_lo[i];
				we[i] = shadow_hi[i];
			end
			rem = shadow_remaining;
			placed = 0;
			dropped = 0;
			for (k = n; k > 0 && !placed && !dropped; k--) begin
				i = k - 1;
				if (e > we[i]) begin
					if (s > ws[i]) begin
						if (s < we[i])
							s = we[i];
						for (j = n; j > i + 1; j--) begin
							ws[j] = ws[j - 1];
							we[j] = we[j - 1];
						end
						ws[i + 1] = s;
						we[i + 1] = e;
						n++;
						rem -= e - s;
						placed = 1;
					end else begin
						rem += we[i] - ws[i];
						for (j = i; j < n - 1; j++) begin
							ws[j] = ws[j + 1];
							we[j] = we[j + 1];
						end
						n--;
					end
				end else if (e < we[i]) begin
					if (s >= ws[i]) begin
						dropped = 1;
					end else if (e >= ws[i]) begin
						rem += e - ws[i];
						ws[i] = e;
					end
				end else begin
					if (s >= ws[i]) begin
						dropped = 1;
					end else begin
						rem += we[i] - ws[i];
						for (j = i; j < n - 1; j++) begin
							ws[j] = ws[j + 1];
							we[j] = we[j + 1];
						end
						n--;
					end
				end
			end
			if (!placed && !dropped) begin
				for (j = n; j > 0; j--) begin
					ws[j] = ws[j - 1];
					we[j] = we[j - 1];
				end
				ws[0] = s;
				we[0] = e;
				n++;
				rem -= e - s;
			end
			if (n > SRT_MAX_SEGMENTS) begin
				r.status = STAT_FULL;
			end else begin
				for (i = 0; i < n; i++) begin
					shadow_lo[i] = ws[i];
					shadow_hi[i] = we[i];
				end
				shadow_count = n;
				shadow_remaining = rem;
				r.status = dropped ? STAT_COVERED : STAT_STORED;
				r.complete = (rem == 0);
			end
		end
		r.bytes_remaining = shadow_remaining;
		return r;
	endfunction

	function automatic seg_item_t make_seg(input logic op, input logic [31:0] s,
			input logic [31:0] e, input logic [31:0] len);
		seg_item_t it;
		it.op = op;
		it.seg_start = s;
		it.seg_end = e;
		it.message_length = len;
		return it;
	endfunction

	function automatic logic [31:0] rand32();
		return $urandom();
	endfunction

	// Driver: one item in flight on the input channel.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid <= 1'b0;
			seg <= '0;
			send_gap <= 0;
		end else if (seg_valid && !seg_stall) begin
			expected_results.push_back(merge_segment(seg));
			if (pending_segs.size() > 0 && !quiet_phase && $urandom_range(0, 5) == 0) begin
				seg_valid <= 1'b0;
				send_gap <= $urandom_range(0, 6);
			end else if (pending_segs.size() > 0 && !drain_hold) begin
				seg <= pending_segs.pop_front();
			end else begin
				seg_valid <= 1'b0;
			end
		end else if (!seg_valid) begin
			if (send_gap > 0)
				send_gap <= send_gap - 1;
			else if (pending_segs.size() > 0 && !drain_hold) begin
				seg_valid <= 1'b1;
				seg <= pending_segs.pop_front();
			end
		end
	end

	// Monitor with random backpressure bursts.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result: status %0d remaining %0h", res.status,
						res.bytes_remaining);
					error_count++;
				end else begin
					res_item_t want;
					want = expected_results.pop_front();
					if (res.complete !== want.complete)
						report_mismatch("complete", 32'(res.complete),
							32'(want.complete));
					if (res.status !== want.status)
						report_mismatch("status", 32'(res.status), 32'(want.status));
					if (res.bytes_remaining !== want.bytes_remaining)
						report_mismatch("bytes_remaining", res.bytes_remaining,
							want.bytes_remaining);
					if (want.complete)
						completions_seen++;
					if (want.status == STAT_FULL)
						full_rejects++;
					if (want.status == STAT_COVERED)
						covered_drops++;
				end
				results_seen++;
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				res_stall <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
				stall_left <= $urandom_range(0, 6);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	int idle_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((seg_valid && !seg_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (!run_done) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[segment_reassembly_tracker_top] ERROR");
				$finish;
			end
		end
	end

	// A message built from segments: mostly well-formed pieces, some noise.
	task automatic queue_message();
		logic [31:0] len, s, e, span;
		int pieces, p, mode;
		mode = $urandom_range(0, 9);
		if (mode == 0)
			len = rand32();
		else if (mode == 1)
			len = 0;
		else
			len = $urandom_range(1, 200);
		pending_segs.push_back(make_seg(OP_OPEN, rand32(), rand32(), len));
		pieces = $urandom_range(3, 30);
		for (p = 0; p < pieces; p++) begin
			if ($urandom_range(0, 12) == 0) begin
				pending_segs.push_back(make_seg(OP_DATA, rand32(), rand32(), rand32()));
			end else if (len > 0) begin
				span = (len > 40 && $urandom_range(0, 3) != 0) ? 8 : len;
				s = (len > 1) ? $urandom_range(0, len - 1) : 0;
				e = s + 1 + $urandom_range(0, span - 1);
				if (e > len || e < s)
					e = len;
				if (mode == 0 && $urandom_range(0, 2) == 0) begin
					s = rand32() % len;
					e = s + 1 + (rand32() % (len - s));
				end
				pending_segs.push_back(make_seg(OP_DATA, s, e, rand32()));
			end else begin
				pending_segs.push_back(make_seg(OP_DATA, 0, 1, rand32()));
			end
		end
		// Finish the message often so completions happen.
		if ($urandom_range(0, 1) == 0 && len != 0 && len <= 200)
			pending_segs.push_back(make_seg(OP_DATA, 0, len, 0));
	endtask

	task automatic wait_drained();
		while (pending_segs.size() > 0 || seg_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		error_count = 0;
		results_seen = 0;
		completions_seen = 0;
		full_rejects = 0;
		covered_drops = 0;
		quiet_phase = 0;
		drain_hold = 0;
		run_done = 0;
		shadow_count = 0;
		shadow_remaining = 0;
		shadow_total = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: data before any open, extremes, overlaps, full table.
		pending_segs.push_back(make_seg(OP_DATA, 0, 1, 0));
		pending_segs.push_back(make_seg(OP_OPEN, '1, '1, 32'd0));
		pending_segs.push_back(make_seg(OP_DATA, 0, '1, '1));
		pending_segs.push_back(make_seg(OP_OPEN, 0, 0, '1));
		pending_segs.push_back(make_seg(OP_DATA, 5, 5, 0));
		pending_segs.push_back(make_seg(OP_DATA, 9, 3, 0));
		pending_segs.push_back(make_seg(OP_DATA, 32'hFFFF_FFFE, '1, 0));
		pending_segs.push_back(make_seg(OP_OPEN, 0, 0, 100));
		pending_segs.push_back(make_seg(OP_DATA, 0, 101, 0));
		pending_segs.push_back(make_seg(OP_DATA, 20, 40, 0));
		pending_segs.push_back(make_seg(OP_DATA, 25, 30, 0));
		pending_segs.push_back(make_seg(OP_DATA, 20, 40, 0));
		pending_segs.push_back(make_seg(OP_DATA, 10, 25, 0));
		pending_segs.push_back(make_seg(OP_DATA, 35, 60, 0));
		pending_segs.push_back(make_seg(OP_DATA, 5, 70, 0));
		pending_segs.push_back(make_seg(OP_DATA, 0, 100, 0));
		pending_segs.push_back(make_seg(OP_DATA, 0, 100, 0));
		pending_segs.push_back(make_seg(OP_OPEN, 0, 0, 64));
		for (i = 0; i < 17; i++)
			pending_segs.push_back(make_seg(OP_DATA, 2 * i, 2 * i + 1, 0));
		// A merge that shrinks the table is still taken when it is full.
		pending_segs.push_back(make_seg(OP_DATA, 0, 64, 0));

		// Wait until every queued segment is sent and every result is back.
		wait_drained();
		repeat (4) @(posedge clk);
		while (pending_segs.size() + results_seen < NUM_RANDOM) begin
			queue_message();
			// The full-table case needs many disjoint pieces.
			if ($urandom_range(0, 7) == 0) begin
				pending_segs.push_back(make_seg(OP_OPEN, 0, 0, 40));
				for (i = 0; i < 18; i++)
					pending_segs.push_back(make_seg(OP_DATA, 2 * i, 2 * i + 1, 0));
			end
		end
		while (pending_segs.size() > 60)
			@(posedge clk);
		quiet_phase = 1;
		for (i = 0; i < 3; i++)
			queue_message();
		wait_drained();
		repeat (20) @(posedge clk);
		run_done = 1;
		$display("covered %0d results: %0d completions, %0d covered drops, %0d full rejects",
			results_seen, completions_seen, covered_drops, full_rejects);
		if (error_count == 0 && expected_results.size() == 0)
			$display("[segment_reassembly_tracker_top] OK");
		else
			$display("[segment_reassembly_tracker_top] ERROR");
		$finish;
	end

endmodule
